// ===== hw/rtl/knapsack_fitness_eval_assert.svh =====
// Assertion macros shared by the knapsack fitness evaluator modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef KNAPSACK_FITNESS_EVAL_ASSERT_SVH
`define KNAPSACK_FITNESS_EVAL_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define KFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define KFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kfe_pkg.sv =====
// Package for the knapsack fitness evaluator: field widths, codes and word types.
// Used by kfe_front, kfe_queue, kfe_back and knapsack_fitness_eval.
package kfe_pkg;

    // Fixed field widths
    localparam int CHROM_W  = 64;
    localparam int IDX_IN_W = 6;
    localparam int IN_VAL_W = 16;
    localparam int OUT_W    = 22;
    localparam int CNT_W    = 7;
    localparam int CAP_W    = 24;
    localparam int ACT_W    = 7;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;

    // Defaults for the top-level parameters
    localparam int KFE_MAX_OBJECTS = 64;
    localparam int KFE_VALUE_BITS  = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 1'b1;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;
    localparam logic [OUT_W-1:0] OUT_MAX      = {OUT_W{1'b1}};

    // Input word
    typedef struct packed {
        logic                kind;
        logic [IDX_IN_W-1:0] obj_index;
        logic [IN_VAL_W-1:0] obj_profit;
        logic [IN_VAL_W-1:0] obj_weight;
        logic [CHROM_W-1:0]  chromosome;
    } t_kfe_in;

    // Result word
    typedef struct packed {
        logic [OUT_W-1:0] fitness;
        logic [OUT_W-1:0] total_weight;
        logic [CNT_W-1:0] selected_count;
        logic             over_capacity;
    } t_kfe_out;

    // Classified word held in the queue; sel has inactive bits cleared
    typedef struct packed {
        logic                kind;
        logic [IDX_IN_W-1:0] obj_index;
        logic [IN_VAL_W-1:0] obj_profit;
        logic [IN_VAL_W-1:0] obj_weight;
        logic [CHROM_W-1:0]  sel;
    } t_kfe_qent;

endpackage

// ===== hw/rtl/knapsack_fitness_eval.sv =====
// Knapsack fitness evaluator: a word passes the front register, queue, stage 1, stage 2
// and result register before o_done; one item per cycle is sustained, since the adder-tree
// back end drains the two-word queue every cycle and busy never rises in steady operation.
// Load words produce no result. Synchronous active-low reset clears the pipeline, queue,
// capacity (0) and active count (64); the object table is not cleared and needs no pass.
module knapsack_fitness_eval #(
    parameter int MAX_OBJECTS = kfe_pkg::KFE_MAX_OBJECTS,
    parameter int VALUE_BITS  = kfe_pkg::KFE_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  kfe_pkg::t_kfe_in              i_item,
    output logic                          o_done,
    output kfe_pkg::t_kfe_out             o_result,
    input  logic                          i_cfg_we,
    input  logic [kfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kfe_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [kfe_pkg::CAP_W-1:0] r_capacity;
    logic [kfe_pkg::ACT_W-1:0] r_active;

    logic               w_push;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_pop;
    kfe_pkg::t_kfe_qent w_front_ent;
    kfe_pkg::t_kfe_qent w_q_ent;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_active   <= kfe_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kfe_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[kfe_pkg::CAP_W-1:0];
                kfe_pkg::CFG_ACTIVE:   r_active   <= i_cfg_data[kfe_pkg::ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    kfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_active (r_active),
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_ent    (w_front_ent)
    );

    kfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_front_ent),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_ent   (w_q_ent)
    );

    kfe_back #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_ent      (w_q_ent),
        .i_capacity (r_capacity),
        .o_pop      (w_pop),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

// ===== hw/rtl/kfe_front.sv =====
// Front end: accepts words, masks chromosome bits beyond the active count.
// Depends on kfe_pkg; feeds kfe_queue.
module kfe_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  kfe_pkg::t_kfe_in          i_item,
    input  logic [kfe_pkg::ACT_W-1:0] i_active,
    input  logic                      i_q_full,
    output logic                      o_busy,
    output logic                      o_push,
    output kfe_pkg::t_kfe_qent        o_ent
);

    logic               r_valid;
    logic               n_valid;
    kfe_pkg::t_kfe_qent r_ent;
    kfe_pkg::t_kfe_qent n_ent;
    logic               w_accept;

    // Hold the word while the queue is full
    assign o_push   = r_valid && !i_q_full;
    assign o_busy   = r_valid && i_q_full;
    assign w_accept = i_start && !o_busy;
    assign o_ent    = r_ent;

    // Classify: copy load fields, clear chromosome bits at or above the active count
    always_comb begin
        n_ent.kind       = i_item.kind;
        n_ent.obj_index  = i_item.obj_index;
        n_ent.obj_profit = i_item.obj_profit;
        n_ent.obj_weight = i_item.obj_weight;
        for (int j = 0; j < kfe_pkg::CHROM_W; j++) begin
            n_ent.sel[j] = i_item.chromosome[j] && (kfe_pkg::ACT_W'(j) < i_active);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ent <= n_ent;
        end
    end

endmodule

// ===== hw/rtl/kfe_queue.sv =====
// Short FIFO between the front end and the evaluation back end.
// Depends on kfe_pkg and the assertion macro header.
`include "knapsack_fitness_eval_assert.svh"
module kfe_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  kfe_pkg::t_kfe_qent i_ent,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output kfe_pkg::t_kfe_qent o_ent
);

    localparam int DEPTH = kfe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kfe_pkg::t_kfe_qent r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_ent    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    `KFE_ASSERT_NOW(a_q_no_overflow, o_full && !w_do_pop, !i_push, "push into a full queue")
    `KFE_ASSERT_NOW(a_q_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `KFE_ASSERT_NEXT(a_q_fill, i_push && !w_do_pop && !o_full, r_count == $past(r_count) + 1'b1,
        "queue count did not follow a push")

endmodule

// ===== hw/rtl/kfe_back.sv =====
// Back end: object table, pipelined profit/weight/count adder tree, capacity test.
// Depends on kfe_pkg and the assertion macro header; drains kfe_queue every cycle.
`include "knapsack_fitness_eval_assert.svh"
module kfe_back #(
    parameter int MAX_OBJECTS = kfe_pkg::KFE_MAX_OBJECTS,
    parameter int VALUE_BITS  = kfe_pkg::KFE_VALUE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  kfe_pkg::t_kfe_qent        i_ent,
    input  logic [kfe_pkg::CAP_W-1:0] i_capacity,
    output logic                      o_pop,
    output logic                      o_done,
    output kfe_pkg::t_kfe_out         o_result
);

    localparam int GRP_SIZE = 8;
    localparam int GROUPS   = (MAX_OBJECTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int LANES    = GROUPS * GRP_SIZE;
    localparam int IDX_W    = $clog2(MAX_OBJECTS);
    localparam int LOAD_W   = (VALUE_BITS < kfe_pkg::IN_VAL_W) ? VALUE_BITS : kfe_pkg::IN_VAL_W;
    localparam int GRP_W    = VALUE_BITS + 3;
    localparam int GCNT_W   = 4;
    localparam int SUM_W    = VALUE_BITS + 6;
    localparam int CMP_W    = (SUM_W > kfe_pkg::CAP_W) ? SUM_W : kfe_pkg::CAP_W;
    localparam int CNT_W    = kfe_pkg::CNT_W;
    localparam int OUT_W    = kfe_pkg::OUT_W;

    // Object table: one register per slot, each feeding its own lane
    logic [VALUE_BITS-1:0] r_tbl_p [MAX_OBJECTS];
    logic [VALUE_BITS-1:0] r_tbl_w [MAX_OBJECTS];

    logic [VALUE_BITS-1:0] w_lane_p [LANES];
    logic [VALUE_BITS-1:0] w_lane_w [LANES];
    logic [LANES-1:0]      w_lane_s;

    logic                  w_load;
    logic                  w_eval;

    // Stage 1: group sums
    logic                  r_s1_valid;
    logic [GRP_W-1:0]      r_grp_p [GROUPS];
    logic [GRP_W-1:0]      r_grp_w [GROUPS];
    logic [GCNT_W-1:0]     r_grp_c [GROUPS];
    logic [GRP_W-1:0]      n_grp_p [GROUPS];
    logic [GRP_W-1:0]      n_grp_w [GROUPS];
    logic [GCNT_W-1:0]     n_grp_c [GROUPS];

    // Stage 2: totals
    logic                  r_s2_valid;
    logic [SUM_W-1:0]      r_sum_p;
    logic [SUM_W-1:0]      r_sum_w;
    logic [CNT_W-1:0]      r_sum_c;
    logic [SUM_W-1:0]      n_sum_p;
    logic [SUM_W-1:0]      n_sum_w;
    logic [CNT_W-1:0]      n_sum_c;

    // Stage 3: result register
    logic                  r_done;
    kfe_pkg::t_kfe_out     r_result;
    kfe_pkg::t_kfe_out     n_result;
    logic                  w_over;

    // Drain the queue every cycle
    assign o_pop  = i_valid;
    assign w_load = i_valid && (i_ent.kind == kfe_pkg::KIND_LOAD);
    assign w_eval = i_valid && (i_ent.kind == kfe_pkg::KIND_EVAL);

    // Write table slots; drop loads beyond the table
    always_ff @(posedge i_clk) begin
        if (w_load && (CNT_W'(i_ent.obj_index) < CNT_W'(MAX_OBJECTS))) begin
            r_tbl_p[i_ent.obj_index[IDX_W-1:0]] <= VALUE_BITS'(i_ent.obj_profit[LOAD_W-1:0]);
            r_tbl_w[i_ent.obj_index[IDX_W-1:0]] <= VALUE_BITS'(i_ent.obj_weight[LOAD_W-1:0]);
        end
    end

    // Gate each lane by its selection bit; lanes past the table read zero
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        if (l < MAX_OBJECTS) begin : g_used
            assign w_lane_s[l] = i_ent.sel[l];
            assign w_lane_p[l] = i_ent.sel[l] ? r_tbl_p[l] : '0;
            assign w_lane_w[l] = i_ent.sel[l] ? r_tbl_w[l] : '0;
        end else begin : g_pad
            assign w_lane_s[l] = 1'b0;
            assign w_lane_p[l] = '0;
            assign w_lane_w[l] = '0;
        end
    end

    // Sum eight lanes per group
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp_p[g] = '0;
            n_grp_w[g] = '0;
            n_grp_c[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                n_grp_p[g] = n_grp_p[g] + GRP_W'(w_lane_p[g*GRP_SIZE + k]);
                n_grp_w[g] = n_grp_w[g] + GRP_W'(w_lane_w[g*GRP_SIZE + k]);
                n_grp_c[g] = n_grp_c[g] + GCNT_W'(w_lane_s[g*GRP_SIZE + k]);
            end
        end
    end

    // Sum the groups
    always_comb begin
        n_sum_p = '0;
        n_sum_w = '0;
        n_sum_c = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_sum_p = n_sum_p + SUM_W'(r_grp_p[g]);
            n_sum_w = n_sum_w + SUM_W'(r_grp_w[g]);
            n_sum_c = n_sum_c + CNT_W'(r_grp_c[g]);
        end
    end

    // Capacity test on the exact weight, then saturate both sums
    assign w_over = CMP_W'(r_sum_w) > CMP_W'(i_capacity);

    always_comb begin
        n_result.over_capacity  = w_over;
        n_result.selected_count = r_sum_c;
        n_result.total_weight   = (CMP_W'(r_sum_w) > CMP_W'(kfe_pkg::OUT_MAX))
                                  ? kfe_pkg::OUT_MAX : OUT_W'(r_sum_w);
        if (w_over) begin
            n_result.fitness = '0;
        end else if (CMP_W'(r_sum_p) > CMP_W'(kfe_pkg::OUT_MAX)) begin
            n_result.fitness = kfe_pkg::OUT_MAX;
        end else begin
            n_result.fitness = OUT_W'(r_sum_p);
        end
    end

    // Advance the pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= w_eval;
            r_s2_valid <= r_s1_valid;
            r_done     <= r_s2_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_grp_p  <= n_grp_p;
        r_grp_w  <= n_grp_w;
        r_grp_c  <= n_grp_c;
        r_sum_p  <= n_sum_p;
        r_sum_w  <= n_sum_w;
        r_sum_c  <= n_sum_c;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `KFE_ASSERT_NEXT(a_bk_s1_to_s2, r_s1_valid, r_s2_valid, "stage 2 lost an item")
    `KFE_ASSERT_NEXT(a_bk_eval_to_done, w_eval, !o_done || $past(r_s2_valid),
        "result strobe without a stage 2 item")
    `KFE_ASSERT_NOW(a_bk_over_zero, o_done && o_result.over_capacity, o_result.fitness == '0,
        "over-capacity result with nonzero fitness")

endmodule
